FILE: design/shva_pkg.sv
// shared types, constants and trig tables for the square hough vote accumulator
package shva_pkg;

    localparam int DEF_MAX_WIDTH  = 32;
    localparam int DEF_MAX_HEIGHT = 32;
    localparam int DEF_SIDE_BINS  = 32;
    localparam int ANGLE_BINS     = 90;
    localparam int ANGLE_W        = 7;
    localparam int TAB_N          = 45;
    localparam int TAB_W          = 31;
    localparam int CNT_W          = 8;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_VOTE_TARGET  = 2'd2;

    localparam logic [5:0] RST_IMAGE_WIDTH  = 6'd32;
    localparam logic [5:0] RST_IMAGE_HEIGHT = 6'd32;
    localparam logic [7:0] RST_VOTE_TARGET  = 8'd4;

    localparam logic OP_VOTE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] Q_ONE  = 64'd1 << 30;

    typedef logic [TAB_W-1:0] trig_tab_t [TAB_N];

    typedef struct packed {
        logic [4:0]         center_x;
        logic [4:0]         center_y;
        logic [ANGLE_W-1:0] angle_bin;
        logic [5:0]         side_bin;
    } geom_result_t;

    // sin or cos of (k + 0.5) degrees in q30, taylor series
    function automatic logic [TAB_W-1:0] trig_q30(int k, bit want_cos);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] st;
        logic [63:0] ct;
        logic [63:0] s;
        logic [63:0] c;
        x  = (64'(2 * k + 1) * PI_Q30) / 360;
        x2 = (x * x) >> 30;
        st = x;
        s  = x;
        ct = Q_ONE;
        c  = Q_ONE;
        st = ((st * x2) >> 30) / 6;   ct = ((ct * x2) >> 30) / 2;   s = s - st; c = c - ct;
        st = ((st * x2) >> 30) / 20;  ct = ((ct * x2) >> 30) / 12;  s = s + st; c = c + ct;
        st = ((st * x2) >> 30) / 42;  ct = ((ct * x2) >> 30) / 30;  s = s - st; c = c - ct;
        st = ((st * x2) >> 30) / 72;  ct = ((ct * x2) >> 30) / 56;  s = s + st; c = c + ct;
        st = ((st * x2) >> 30) / 110; ct = ((ct * x2) >> 30) / 90;  s = s - st; c = c - ct;
        st = ((st * x2) >> 30) / 156; ct = ((ct * x2) >> 30) / 132; s = s + st; c = c + ct;
        st = ((st * x2) >> 30) / 210; ct = ((ct * x2) >> 30) / 182; s = s - st; c = c - ct;
        st = ((st * x2) >> 30) / 272; ct = ((ct * x2) >> 30) / 240; s = s + st; c = c + ct;
        return want_cos ? c[TAB_W-1:0] : s[TAB_W-1:0];
    endfunction

    function automatic trig_tab_t build_tab(bit want_cos);
        trig_tab_t t;
        for (int k = 0; k < TAB_N; k++)
        begin
            t[k] = trig_q30(k, want_cos);
        end
        return t;
    endfunction

    localparam trig_tab_t SIN_TAB = build_tab(1'b0);
    localparam trig_tab_t COS_TAB = build_tab(1'b1);

    // base + off - 1, held to 0..top
    function automatic logic [9:0] clamp_off(logic [9:0] base, logic [1:0] off,
                                             logic [9:0] top);
        logic [9:0] t;
        t = base + 10'(off);
        if (t == 10'd0)
        begin
            return 10'd0;
        end
        t = t - 10'd1;
        return (t > top) ? top : t;
    endfunction

endpackage

FILE: design/square_hough_vote_accumulator.sv
// square hough vote accumulator top level: sequencer, accumulator memory, ports
// A vote beat runs the squaring and side search and then the angle compares on the one
// shared multiplier in the geometry unit, then the 81 read-modify-writes of the single-port
// count memory, each a read state and then a write state. A query beat reads the memory
// and then waits for as long as the output is stalled.
// After reset the block runs a clearing pass that writes zero to every memory word
// (4194304 words at the default sizes), during which in_stall is high; configuration
// writes are taken.
module square_hough_vote_accumulator #(
    parameter int MAX_WIDTH  = shva_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = shva_pkg::DEF_MAX_HEIGHT,
    parameter int SIDE_BINS  = shva_pkg::DEF_SIDE_BINS
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       op,
    input  logic [4:0] first_x,
    input  logic [4:0] first_y,
    input  logic [4:0] second_x,
    input  logic [4:0] second_y,
    input  logic [4:0] query_x,
    input  logic [4:0] query_y,
    input  logic [6:0] query_angle,
    input  logic [4:0] query_side,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] center_x,
    output logic [4:0] center_y,
    output logic [6:0] angle_bin,
    output logic [5:0] side_bin,
    output logic [7:0] vote_count,
    output logic       is_candidate,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import shva_pkg::*;

    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int SW     = $clog2(SIDE_BINS);
    localparam int ADDR_W = XW + YW + ANGLE_W + SW;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_GEOM  = 3'd2;
    localparam logic [2:0] ST_VRD   = 3'd3;
    localparam logic [2:0] ST_VWR   = 3'd4;
    localparam logic [2:0] ST_QRD   = 3'd5;
    localparam logic [2:0] ST_QDAT  = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [5:0]        width_reg, height_reg;
    logic [7:0]        target_reg;
    logic [1:0]        ox_reg, oy_reg, oa_reg, os_reg;
    logic [ADDR_W-1:0] qaddr_reg;

    logic              out_valid_reg;
    logic [4:0]        cx_out_reg, cy_out_reg;
    logic [6:0]        ang_out_reg;
    logic [5:0]        side_out_reg;
    logic [7:0]        cnt_out_reg;
    logic              cand_out_reg;

    logic              accept;
    logic              out_free;
    logic              geom_done;
    geom_result_t      gres;
    logic [9:0]        w_lim, h_lim, s_lim;
    logic [9:0]        cell_x, cell_y, cell_a, cell_s;
    logic [9:0]        qx, qy, qa, qs;
    logic [ADDR_W-1:0] vote_addr, q_addr, ram_addr;
    logic              ram_we;
    logic [7:0]        ram_wdata, ram_rdata;
    logic              last_cell;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    shva_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && op == OP_VOTE),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .done     (geom_done),
        .result   (gres)
    );

    // table limits from the size registers
    always_comb
    begin
        w_lim = (width_reg == 6'd0) ? 10'd1 :
                (10'(width_reg) > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : 10'(width_reg);
        h_lim = (height_reg == 6'd0) ? 10'd1 :
                (10'(height_reg) > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : 10'(height_reg);
        s_lim = (w_lim < h_lim) ? w_lim : h_lim;
        if (s_lim > 10'(SIDE_BINS))
        begin
            s_lim = 10'(SIDE_BINS);
        end
        cell_x = clamp_off(10'(gres.center_x), ox_reg, w_lim - 10'd1);
        cell_y = clamp_off(10'(gres.center_y), oy_reg, h_lim - 10'd1);
        cell_a = clamp_off(10'(gres.angle_bin), oa_reg, 10'(ANGLE_BINS - 1));
        cell_s = clamp_off(10'(gres.side_bin), os_reg, s_lim - 10'd1);
        vote_addr = {cell_x[XW-1:0], cell_y[YW-1:0], cell_a[ANGLE_W-1:0], cell_s[SW-1:0]};

        qx = (10'(query_x) > 10'(MAX_WIDTH - 1)) ? 10'(MAX_WIDTH - 1) : 10'(query_x);
        qy = (10'(query_y) > 10'(MAX_HEIGHT - 1)) ? 10'(MAX_HEIGHT - 1) : 10'(query_y);
        qa = (10'(query_angle) > 10'(ANGLE_BINS - 1)) ? 10'(ANGLE_BINS - 1)
                                                        : 10'(query_angle);
        qs = (10'(query_side) > 10'(SIDE_BINS - 1)) ? 10'(SIDE_BINS - 1) : 10'(query_side);
        q_addr = {qx[XW-1:0], qy[YW-1:0], qa[ANGLE_W-1:0], qs[SW-1:0]};
    end

    assign last_cell = (ox_reg == 2'd2) && (oy_reg == 2'd2) &&
                       (oa_reg == 2'd2) && (os_reg == 2'd2);

    always_comb
    begin
        case (state_reg)
            ST_CLEAR:           ram_addr = clr_addr_reg;
            ST_QRD, ST_QDAT:    ram_addr = qaddr_reg;
            default:            ram_addr = vote_addr;
        endcase
    end

    assign ram_we    = (state_reg == ST_CLEAR) || (state_reg == ST_VWR);
    assign ram_wdata = (state_reg == ST_CLEAR) ? 8'd0 : (ram_rdata + 8'd1);

    shva_ram #(
        .WIDTH (CNT_W),
        .DEPTH (1 << ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (&clr_addr_reg) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op == OP_VOTE) ? ST_GEOM : ST_QRD;
                end
            end
            ST_GEOM:  if (geom_done) state_next = ST_VRD;
            ST_VRD:   state_next = ST_VWR;
            ST_VWR:   state_next = last_cell ? ST_DONE : ST_VRD;
            ST_QRD:   state_next = ST_QDAT;
            ST_QDAT:  if (out_free) state_next = ST_IDLE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            width_reg     <= RST_IMAGE_WIDTH;
            height_reg    <= RST_IMAGE_HEIGHT;
            target_reg    <= RST_VOTE_TARGET;
            out_valid_reg <= 1'b0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oa_reg        <= '0;
            os_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[5:0];
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data[5:0];
                    CFG_VOTE_TARGET:  target_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            // ternary odometer over the 81 neighbor cells
            if (state_reg == ST_VWR)
            begin
                if (os_reg != 2'd2)
                begin
                    os_reg <= os_reg + 2'd1;
                end
                else
                begin
                    os_reg <= '0;
                    if (oa_reg != 2'd2)
                    begin
                        oa_reg <= oa_reg + 2'd1;
                    end
                    else
                    begin
                        oa_reg <= '0;
                        if (oy_reg != 2'd2)
                        begin
                            oy_reg <= oy_reg + 2'd1;
                        end
                        else
                        begin
                            oy_reg <= '0;
                            ox_reg <= (ox_reg != 2'd2) ? ox_reg + 2'd1 : 2'd0;
                        end
                    end
                end
            end
            if ((state_reg == ST_QDAT || state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qaddr_reg <= q_addr;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            cx_out_reg   <= gres.center_x;
            cy_out_reg   <= gres.center_y;
            ang_out_reg  <= gres.angle_bin;
            side_out_reg <= gres.side_bin;
            cnt_out_reg  <= 8'd0;
            cand_out_reg <= 1'b0;
        end
        else if (state_reg == ST_QDAT && out_free)
        begin
            cx_out_reg   <= 5'd0;
            cy_out_reg   <= 5'd0;
            ang_out_reg  <= 7'd0;
            side_out_reg <= 6'd0;
            cnt_out_reg  <= ram_rdata;
            cand_out_reg <= (ram_rdata == target_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign center_x     = cx_out_reg;
    assign center_y     = cy_out_reg;
    assign angle_bin    = ang_out_reg;
    assign side_bin     = side_out_reg;
    assign vote_count   = cnt_out_reg;
    assign is_candidate = cand_out_reg;

    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_VWR))
        else $error("memory write outside clear or vote update");

    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_VWR |-> $past(state_reg) == ST_VRD)
        else $error("vote update without preceding read");

    a_geom_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        geom_done |-> state_reg == ST_GEOM)
        else $error("geometry result outside geometry wait");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE || $past(state_reg) == ST_QDAT))
        else $error("result beat without finished item");

endmodule

FILE: design/shva_ram.sv
// generic single-port ram with registered read
module shva_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/shva_geom.sv
// diagonal geometry unit: center, side and angle bin on one shared multiplier
module shva_geom (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [4:0]            first_x,
    input  logic [4:0]            first_y,
    input  logic [4:0]            second_x,
    input  logic [4:0]            second_y,
    output logic                  done,
    output shva_pkg::geom_result_t result
);
    import shva_pkg::*;

    localparam logic [2:0] G_IDLE = 3'd0;
    localparam logic [2:0] G_SQX  = 3'd1;
    localparam logic [2:0] G_SQY  = 3'd2;
    localparam logic [2:0] G_SIDE = 3'd3;
    localparam logic [2:0] G_ANG0 = 3'd4;
    localparam logic [2:0] G_ANG1 = 3'd5;
    localparam logic [2:0] G_DONE = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  adx_reg, ady_reg, p_reg, q_reg;
    logic        flip_reg;
    logic [4:0]  cx_reg, cy_reg;
    logic [10:0] acc_reg;
    logic [5:0]  n_reg;
    logic [5:0]  k_reg;
    logic [5:0]  cnt_reg;
    logic [37:0] lhs_reg;

    logic signed [5:0] dx, dy;
    logic [4:0]  u, v;
    logic [5:0]  csum_x, csum_y;
    logic [TAB_W-1:0] mul_a;
    logic [6:0]  mul_b;
    logic [37:0] prod;
    logic [11:0] twice;
    logic [6:0]  r;
    logic [6:0]  ang;

    always_comb
    begin
        dx = $signed({1'b0, first_x}) - $signed({1'b0, second_x});
        dy = $signed({1'b0, first_y}) - $signed({1'b0, second_y});
        csum_x = {1'b0, first_x} + {1'b0, second_x};
        csum_y = {1'b0, first_y} + {1'b0, second_y};
        if (dx == 6'sd0 && dy == 6'sd0)
        begin
            u = 5'd1;
            v = 5'd0;
        end
        else if (dx > 6'sd0 && dy >= 6'sd0)
        begin
            u = dx[4:0];
            v = dy[4:0];
        end
        else if (dx <= 6'sd0 && dy > 6'sd0)
        begin
            u = dy[4:0];
            v = 5'(-dx);
        end
        else if (dx < 6'sd0 && dy <= 6'sd0)
        begin
            u = 5'(-dx);
            v = 5'(-dy);
        end
        else
        begin
            u = 5'(-dy);
            v = dx[4:0];
        end
    end

    always_comb
    begin
        case (state_reg)
            G_SQX:
            begin
                mul_a = TAB_W'(adx_reg);
                mul_b = 7'(adx_reg);
            end
            G_SQY:
            begin
                mul_a = TAB_W'(ady_reg);
                mul_b = 7'(ady_reg);
            end
            G_SIDE:
            begin
                mul_a = TAB_W'({n_reg, 1'b1});
                mul_b = {n_reg, 1'b1};
            end
            G_ANG0:
            begin
                mul_a = COS_TAB[k_reg];
                mul_b = 7'(p_reg);
            end
            G_ANG1:
            begin
                mul_a = SIN_TAB[k_reg];
                mul_b = 7'(q_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod  = 38'(mul_a) * 38'(mul_b);
    assign twice = {acc_reg, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            G_IDLE: if (start) state_next = G_SQX;
            G_SQX:  state_next = G_SQY;
            G_SQY:  state_next = G_SIDE;
            G_SIDE: if (prod > 38'(twice)) state_next = G_ANG0;
            G_ANG0: state_next = G_ANG1;
            G_ANG1: if (k_reg == 6'(TAB_N - 1)) state_next = G_DONE; else state_next = G_ANG0;
            G_DONE: state_next = G_IDLE;
            default: state_next = G_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            G_IDLE:
            begin
                if (start)
                begin
                    adx_reg  <= (dx < 6'sd0) ? 5'(-dx) : dx[4:0];
                    ady_reg  <= (dy < 6'sd0) ? 5'(-dy) : dy[4:0];
                    flip_reg <= (v > u);
                    p_reg    <= (v > u) ? u : v;
                    q_reg    <= (v > u) ? v : u;
                    cx_reg   <= csum_x[5:1];
                    cy_reg   <= csum_y[5:1];
                end
            end
            G_SQX:
            begin
                acc_reg <= 11'(prod);
                n_reg   <= '0;
            end
            G_SQY:
            begin
                acc_reg <= acc_reg + 11'(prod);
            end
            G_SIDE:
            begin
                k_reg   <= '0;
                cnt_reg <= '0;
                if (prod <= 38'(twice))
                begin
                    n_reg <= n_reg + 6'd1;
                end
            end
            G_ANG0:
            begin
                lhs_reg <= prod;
            end
            G_ANG1:
            begin
                if (lhs_reg > prod)
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
                k_reg <= k_reg + 6'd1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        r   = flip_reg ? (7'(ANGLE_BINS) - 7'(cnt_reg)) : 7'(cnt_reg);
        ang = (r >= 7'd45) ? (r - 7'd45) : (r + 7'd45);
    end

    assign done               = (state_reg == G_DONE);
    assign result.center_x    = cx_reg;
    assign result.center_y    = cy_reg;
    assign result.angle_bin   = ang;
    assign result.side_bin    = n_reg;

endmodule

FILE: sim/square_hough_vote_accumulator_tb.sv
// self-checking testbench for the square hough vote accumulator: directed table, then random beats
module square_hough_vote_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import shva_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd16000000;

    typedef struct {
        bit       op;
        bit [4:0] cx;
        bit [4:0] cy;
        bit [6:0] ang;
        bit [5:0] side;
        bit [7:0] cnt;
        bit       cand;
    } square_result_t;

    typedef struct {
        int op; int fx; int fy; int sx; int sy; int qx; int qy; int qa; int qs;
        bit typed;
        int ecx; int ecy; int eang; int eside; int ecnt; int ecand;
    } stim_row_t;

    stim_row_t directed_rows [16] = '{
        '{1, 0, 0, 0, 0, 0, 0, 0, 0,      1, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 0, 31, 31, 127, 31, 1, 0, 0, 0, 0, 0, 0},
        '{0, 5, 5, 5, 5, 0, 0, 0, 0,      1, 5, 5, 45, 0, 0, 0},
        '{1, 0, 0, 0, 0, 5, 5, 45, 0,     1, 0, 0, 0, 0, 2, 0},
        '{0, 0, 0, 31, 31, 0, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0},
        '{0, 31, 31, 0, 0, 0, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0},
        '{0, 31, 0, 0, 31, 0, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 31, 31, 0, 0, 0, 0, 0,    0, 0, 0, 0, 0, 0, 0},
        '{0, 10, 10, 20, 10, 0, 0, 0, 0,  0, 0, 0, 0, 0, 0, 0},
        '{0, 20, 10, 10, 10, 0, 0, 0, 0,  0, 0, 0, 0, 0, 0, 0},
        '{0, 10, 20, 10, 10, 0, 0, 0, 0,  0, 0, 0, 0, 0, 0, 0},
        '{0, 10, 0, 10, 31, 0, 0, 0, 0,   0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 0, 31, 31, 89, 31,  0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 0, 0, 0, 15, 15, 45, 14,  0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0,      1, 0, 0, 45, 0, 0, 0},
        '{1, 0, 0, 0, 0, 0, 0, 45, 0,     0, 0, 0, 0, 0, 0, 0}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       op;
    logic [4:0] first_x;
    logic [4:0] first_y;
    logic [4:0] second_x;
    logic [4:0] second_y;
    logic [4:0] query_x;
    logic [4:0] query_y;
    logic [6:0] query_angle;
    logic [4:0] query_side;
    logic       out_valid;
    logic       out_stall;
    logic [4:0] center_x;
    logic [4:0] center_y;
    logic [6:0] angle_bin;
    logic [5:0] side_bin;
    logic [7:0] vote_count;
    logic       is_candidate;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    square_hough_vote_accumulator dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .first_x(first_x), .first_y(first_y), .second_x(second_x), .second_y(second_y),
        .query_x(query_x), .query_y(query_y), .query_angle(query_angle),
        .query_side(query_side), .out_valid(out_valid), .out_stall(out_stall),
        .center_x(center_x), .center_y(center_y), .angle_bin(angle_bin),
        .side_bin(side_bin), .vote_count(vote_count), .is_candidate(is_candidate),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    longint unsigned half_deg_tan [45];
    bit [7:0]        cell_counts [int];
    int unsigned     width_reg;
    int unsigned     height_reg;
    int unsigned     target_reg;
    square_result_t  pending_results [$];
    int              error_count;
    longint          cycle_count;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_requests;
    int              hold_served;
    int              anchor_x;
    int              anchor_y;
    int              last_cx;
    int              last_cy;
    int              last_ang;
    int              last_side;
    bit              burst_enable;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic build_tan_table();
        longint unsigned x, x2, st, s, ct, c;
        for (int k = 0; k < 45; k++)
        begin
            x  = (longint'(2 * k + 1) * 64'd3373259426) / 360;
            x2 = (x * x) >> 30;
            st = x; s = x; ct = 64'd1 << 30; c = ct;
            for (int n = 1; n <= 8; n++)
            begin
                st = ((st * x2) >> 30) / ((2 * n) * (2 * n + 1));
                ct = ((ct * x2) >> 30) / ((2 * n - 1) * (2 * n));
                if (n % 2 == 1)
                begin
                    s = s - st; c = c - ct;
                end
                else
                begin
                    s = s + st; c = c + ct;
                end
            end
            half_deg_tan[k] = (s << 30) / c;
        end
    endtask

    function automatic int slope_bins(longint unsigned p, longint unsigned q);
        int n;
        n = 0;
        for (int k = 0; k < 45; k++)
        begin
            if ((p << 30) > q * half_deg_tan[k])
            begin
                n++;
            end
        end
        return n;
    endfunction

    function automatic int diagonal_angle(int dx, int dy);
        int u, v, r;
        if (dx == 0 && dy == 0)
        begin
            u = 1; v = 0;
        end
        else if (dx > 0 && dy >= 0)
        begin
            u = dx; v = dy;
        end
        else if (dx <= 0 && dy > 0)
        begin
            u = dy; v = -dx;
        end
        else if (dx < 0 && dy <= 0)
        begin
            u = -dx; v = -dy;
        end
        else
        begin
            u = -dy; v = dx;
        end
        if (v <= u)
        begin
            r = slope_bins(v, u);
        end
        else
        begin
            r = 90 - slope_bins(u, v);
        end
        return (r + 45) % 90;
    endfunction

    function automatic int hold_in(int v, int top);
        if (v < 0)
        begin
            return 0;
        end
        return (v > top) ? top : v;
    endfunction

    function automatic int cell_key(int a, int b, int c, int d);
        return ((a * 32 + b) * 90 + c) * 32 + d;
    endfunction

    function automatic square_result_t predict_square(stim_row_t r);
        square_result_t res;
        int dx, dy, cx, cy, ang, side, w, h, sl, key, twice;
        res = '{default: 0};
        res.op = r.op[0];
        if (r.op == 0)
        begin
            dx = r.fx - r.sx;
            dy = r.fy - r.sy;
            cx = (r.fx + r.sx) >> 1;
            cy = (r.fy + r.sy) >> 1;
            ang = diagonal_angle(dx, dy);
            twice = 2 * (dx * dx + dy * dy);
            side = 0;
            while ((2 * side + 1) * (2 * side + 1) <= twice)
            begin
                side++;
            end
            w = (width_reg < 1) ? 1 : ((width_reg > 32) ? 32 : width_reg);
            h = (height_reg < 1) ? 1 : ((height_reg > 32) ? 32 : height_reg);
            sl = (w < h) ? w : h;
            for (int i = -1; i <= 1; i++)
                for (int j = -1; j <= 1; j++)
                    for (int k = -1; k <= 1; k++)
                        for (int m = -1; m <= 1; m++)
                        begin
                            key = cell_key(hold_in(cx + i, w - 1), hold_in(cy + j, h - 1),
                                           hold_in(ang + k, 89), hold_in(side + m, sl - 1));
                            if (cell_counts.exists(key))
                            begin
                                cell_counts[key] = cell_counts[key] + 8'd1;
                            end
                            else
                            begin
                                cell_counts[key] = 8'd1;
                            end
                        end
            res.cx = cx[4:0]; res.cy = cy[4:0]; res.ang = ang[6:0]; res.side = side[5:0];
            last_cx = cx; last_cy = cy; last_ang = ang; last_side = side;
        end
        else
        begin
            key = cell_key(r.qx, r.qy, hold_in(r.qa, 89), r.qs);
            res.cnt = cell_counts.exists(key) ? cell_counts[key] : 8'd0;
            res.cand = (res.cnt == target_reg[7:0]);
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic send_beat(stim_row_t r);
        square_result_t res;
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(6, 1)) @(negedge clk);
        end
        op = r.op[0];
        first_x = r.fx[4:0]; first_y = r.fy[4:0];
        second_x = r.sx[4:0]; second_y = r.sy[4:0];
        query_x = r.qx[4:0]; query_y = r.qy[4:0];
        query_angle = r.qa[6:0]; query_side = r.qs[4:0];
        in_valid = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        res = predict_square(r);
        if (r.typed)
        begin
            res.cx = r.ecx[4:0]; res.cy = r.ecy[4:0]; res.ang = r.eang[6:0];
            res.side = r.eside[5:0]; res.cnt = r.ecnt[7:0]; res.cand = r.ecand[0];
        end
        pending_results.insert(pending_results.size(), res);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge clk);
        in_valid = 1'b0;
        cfg_write = 1'b1; cfg_index = idx; cfg_data = value[7:0];
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx == CFG_IMAGE_WIDTH)
        begin
            width_reg = value & 6'h3f;
        end
        else if (idx == CFG_IMAGE_HEIGHT)
        begin
            height_reg = value & 6'h3f;
        end
        else
        begin
            target_reg = value & 8'hff;
        end
    endtask

    task automatic settle_and_configure(int w, int h, int tgt);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_VOTE_TARGET, tgt);
    endtask

    task automatic random_beats(int count);
        stim_row_t r;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            r = '{default: 0};
            pick = $urandom_range(99);
            r.qx = $urandom_range(31); r.qy = $urandom_range(31);
            r.qa = $urandom_range(127); r.qs = $urandom_range(31);
            r.fx = $urandom_range(31); r.fy = $urandom_range(31);
            r.sx = $urandom_range(31); r.sy = $urandom_range(31);
            if (burst_enable && pick < 10)
            begin
                r.fx = 0; r.fy = 0; r.sx = 0; r.sy = 0;
            end
            else if (pick < 55)
            begin
                r.fx = hold_in(anchor_x + $urandom_range(8) - 4, 31);
                r.fy = hold_in(anchor_y + $urandom_range(8) - 4, 31);
                r.sx = hold_in(anchor_x + 6 + $urandom_range(8) - 4, 31);
                r.sy = hold_in(anchor_y + 6 + $urandom_range(8) - 4, 31);
            end
            else if (pick >= 70)
            begin
                r.op = 1;
                if (pick < 88)
                begin
                    r.qx = hold_in(last_cx + $urandom_range(2) - 1, 31);
                    r.qy = hold_in(last_cy + $urandom_range(2) - 1, 31);
                    r.qa = hold_in(last_ang + $urandom_range(2) - 1, 127);
                    r.qs = hold_in(last_side + $urandom_range(2) - 1, 31);
                end
            end
            send_beat(r);
        end
    endtask

    always @(posedge clk)
    begin
        square_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected beat", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (center_x !== want.cx) report_mismatch("center_x", center_x, want.cx);
                if (center_y !== want.cy) report_mismatch("center_y", center_y, want.cy);
                if (angle_bin !== want.ang) report_mismatch("angle_bin", angle_bin, want.ang);
                if (side_bin !== want.side) report_mismatch("side_bin", side_bin, want.side);
                if (vote_count !== want.cnt) report_mismatch("vote_count", vote_count, want.cnt);
                if (is_candidate !== want.cand)
                    report_mismatch("is_candidate", is_candidate, want.cand);
            end
        end
    end

    initial
    begin
        int hold_left;
        out_stall = 1'b1;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = 3000;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall = 1'b1;
            end
            else
            begin
                out_stall = ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial
    begin
        error_count = 0; cycle_count = 0;
        hold_requests = 0; hold_served = 0; burst_enable = 0;
        send_idle_pct = 30; recv_idle_pct = 45;
        width_reg = RST_IMAGE_WIDTH; height_reg = RST_IMAGE_HEIGHT;
        target_reg = RST_VOTE_TARGET;
        last_cx = 0; last_cy = 0; last_ang = 45; last_side = 0;
        anchor_x = 8; anchor_y = 8;
        rst_n = 1'b0; in_valid = 1'b0; op = OP_VOTE;
        first_x = '0; first_y = '0; second_x = '0; second_y = '0;
        query_x = '0; query_y = '0; query_angle = '0; query_side = '0;
        cfg_write = 1'b0; cfg_index = CFG_IMAGE_WIDTH; cfg_data = '0;
        build_tan_table();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i]);
        end
        random_beats(480);

        settle_and_configure(0, 63, 0);
        send_idle_pct = 45; recv_idle_pct = 30;
        anchor_x = 2; anchor_y = 20;
        random_beats(380);

        settle_and_configure(17, 9, 255);
        send_idle_pct = 0; recv_idle_pct = 0;
        burst_enable = 1; anchor_x = 12; anchor_y = 2;
        hold_requests++;
        random_beats(400);

        settle_and_configure(1, 32, 3);
        burst_enable = 0;
        send_idle_pct = 30; recv_idle_pct = 45;
        anchor_x = 20; anchor_y = 14;
        random_beats(320);

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (400) @(posedge clk);
        if (error_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
